>>> sv/swap_permutation_generator_top_macros.svh
// Assertion macros for the swap permutation generator
`ifndef SWAP_PERMUTATION_GENERATOR_TOP_MACROS_SVH
`define SWAP_PERMUTATION_GENERATOR_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SPG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swap permutation generator check failed");

// next-cycle implication, sampled on clk, off during reset
`define SPG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swap permutation generator check failed");

`endif

>>> sv/spg_pkg.sv
`timescale 1ns / 1ps
package spg_pkg;

  localparam int MAX_ELEMENTS = 8;
  localparam int RESULT_LIMIT = 8;
  localparam int N_MAX  = (MAX_ELEMENTS < RESULT_LIMIT) ? MAX_ELEMENTS : RESULT_LIMIT;
  localparam int ADDR_W = $clog2(MAX_ELEMENTS);
  localparam int N_W    = $clog2(N_MAX + 1);
  localparam int CNT_W  = 4;
  localparam int POS_W  = 3;
  localparam int DATA_W = 32;
  localparam int PC_W   = 5;
  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(5);

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [1:0] {RD_NONE, RD_LVL, RD_IDX, RD_EMIT} rd_sel_t;
  typedef enum logic [1:0] {WR_NONE, WR_LVL, WR_IDX} wr_sel_t;
  typedef enum logic [3:0] {
    OP_NONE, OP_SETK, OP_LOADIDX, OP_INCIDX, OP_COMMIT,
    OP_RESTORE, OP_DESCEND0, OP_FINISH, OP_DONE
  } op_t;
  typedef enum logic [2:0] {
    JC_NONE, JC_ALWAYS, JC_FIN, JC_NEW, JC_KZERO, JC_IDXGE, JC_MORE
  } cond_t;

  typedef struct packed {
    rd_sel_t rd;
    wr_sel_t wr;
    logic    tmp_ld;
    op_t     op;
    cond_t   cond;
    pc_t     target;
    logic    fin;
  } ucw_t;

  localparam pc_t S_DISPATCH = pc_t'(0);
  localparam pc_t S_NEWCHK   = pc_t'(1);
  localparam pc_t S_LOOP     = pc_t'(2);
  localparam pc_t S_RESTORE  = pc_t'(12);
  localparam pc_t S_FIRST    = pc_t'(13);
  localparam pc_t S_EXHAUST  = pc_t'(14);
  localparam pc_t S_DONE     = pc_t'(15);
  localparam pc_t S_EMIT     = pc_t'(16);
  localparam pc_t S_TAIL     = pc_t'(17);

  localparam ucw_t UCW_IDLE = '{RD_NONE, WR_NONE, 1'b0, OP_NONE, JC_NONE, S_DISPATCH, 1'b1};

  function automatic ucw_t ucode(input pc_t pc);
    ucw_t w;
    unique case (pc)
      S_DISPATCH: w = '{RD_NONE, WR_NONE, 1'b0, OP_SETK,     JC_FIN,    S_DONE,    1'b0};
      S_NEWCHK:   w = '{RD_NONE, WR_NONE, 1'b0, OP_NONE,     JC_NEW,    S_FIRST,   1'b0};
      S_LOOP:     w = '{RD_NONE, WR_NONE, 1'b0, OP_LOADIDX,  JC_KZERO,  S_EXHAUST, 1'b0};
      pc_t'(3):   w = '{RD_LVL,  WR_NONE, 1'b0, OP_NONE,     JC_NONE,   S_DISPATCH, 1'b0};
      pc_t'(4):   w = '{RD_IDX,  WR_NONE, 1'b1, OP_NONE,     JC_NONE,   S_DISPATCH, 1'b0};
      pc_t'(5):   w = '{RD_NONE, WR_LVL,  1'b0, OP_NONE,     JC_NONE,   S_DISPATCH, 1'b0};
      pc_t'(6):   w = '{RD_NONE, WR_IDX,  1'b0, OP_INCIDX,   JC_NONE,   S_DISPATCH, 1'b0};
      pc_t'(7):   w = '{RD_NONE, WR_NONE, 1'b0, OP_NONE,     JC_IDXGE,  S_RESTORE, 1'b0};
      pc_t'(8):   w = '{RD_LVL,  WR_NONE, 1'b0, OP_COMMIT,   JC_NONE,   S_DISPATCH, 1'b0};
      pc_t'(9):   w = '{RD_IDX,  WR_NONE, 1'b1, OP_NONE,     JC_NONE,   S_DISPATCH, 1'b0};
      pc_t'(10):  w = '{RD_NONE, WR_LVL,  1'b0, OP_NONE,     JC_NONE,   S_DISPATCH, 1'b0};
      pc_t'(11):  w = '{RD_NONE, WR_IDX,  1'b0, OP_NONE,     JC_ALWAYS, S_EMIT,    1'b0};
      S_RESTORE:  w = '{RD_NONE, WR_NONE, 1'b0, OP_RESTORE,  JC_ALWAYS, S_LOOP,    1'b0};
      S_FIRST:    w = '{RD_NONE, WR_NONE, 1'b0, OP_DESCEND0, JC_ALWAYS, S_EMIT,    1'b0};
      S_EXHAUST:  w = '{RD_NONE, WR_NONE, 1'b0, OP_FINISH,   JC_ALWAYS, S_DONE,    1'b0};
      S_DONE:     w = '{RD_NONE, WR_NONE, 1'b0, OP_DONE,     JC_NONE,   S_DISPATCH, 1'b1};
      S_EMIT:     w = '{RD_EMIT, WR_NONE, 1'b0, OP_NONE,     JC_MORE,   S_EMIT,    1'b0};
      S_TAIL:     w = '{RD_NONE, WR_NONE, 1'b0, OP_NONE,     JC_NONE,   S_DISPATCH, 1'b1};
      default:    w = UCW_IDLE;
    endcase
    return w;
  endfunction

endpackage

>>> sv/swap_permutation_generator_top.sv
`timescale 1ns / 1ps
// Swap permutation generator.
// Input channel: an item transfers on a clock edge with start high and busy low.
//   action 0 loads value into position (no result) and restarts the
//   enumeration; action 1 asks for the next permutation of the first n positions.
// Configuration: wr_en with wr_data writes n (count_in_use, 0 reads as 1, above 8 as 8) and
//   restarts the enumeration. Write only while busy is low.
// Results: one element per cycle, each shown for one cycle with strobe high.
//   last_element marks the final element; after all n! permutations each request
//   gives one result with done_res and last_element high and zero value fields.
// Sequencing: a microcoded sequencer runs each request. The first request
//   descends and then emits. A later one dispatches, unwinds the stack levels
//   it must, swaps and re-descends, then emits over the single working array
//   read port. The request that runs out unwinds its levels and ends with a
//   done result; once finished, each request gives a done result.
// Reset: the enumeration state clears and n returns to 5; array contents stay
//   undefined until loaded. The receiver cannot stall: every strobe is a
//   transfer.
module swap_permutation_generator_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         action,
  input  logic [spg_pkg::POS_W-1:0]    position,
  input  logic signed [spg_pkg::DATA_W-1:0] value,
  input  logic                         wr_en,
  input  logic [spg_pkg::CNT_W-1:0]    wr_data,
  output logic                         strobe,
  output logic [spg_pkg::POS_W-1:0]    out_position,
  output logic signed [spg_pkg::DATA_W-1:0] out_value,
  output logic                         last_element,
  output logic                         done_res
);
  import spg_pkg::*;

  logic [DATA_W-1:0] mem [MAX_ELEMENTS];
  logic [DATA_W-1:0] rdata;
  logic [DATA_W-1:0] tmp;
  logic [ADDR_W-1:0] level_index [MAX_ELEMENTS];
  logic [CNT_W-1:0]  count_in_use;
  logic              run;
  pc_t               pc;
  logic              started;
  logic              finished;
  logic [N_W-1:0]    k;
  logic [N_W-1:0]    idx;
  logic [N_W-1:0]    e;

  ucw_t              cw;
  logic [N_W-1:0]    n;
  logic [N_W-1:0]    lvl;
  logic              jump;
  logic              take;
  logic              load_take;
  logic [ADDR_W-1:0] raddr;

  assign busy      = run;
  assign take      = start && !run;
  assign load_take = take && !action;
  assign lvl       = k - N_W'(1);
  assign out_value = done_res ? '0 : signed'(rdata);

  always_comb begin
    if (count_in_use == '0) begin
      n = N_W'(1);
    end else if (32'(count_in_use) > N_MAX) begin
      n = N_W'(N_MAX);
    end else begin
      n = N_W'(count_in_use);
    end
  end

  always_comb begin
    cw = run ? ucode(pc) : UCW_IDLE;
  end

  always_comb begin
    unique case (cw.cond)
      JC_NONE:   jump = 1'b0;
      JC_ALWAYS: jump = 1'b1;
      JC_FIN:    jump = finished;
      JC_NEW:    jump = !started;
      JC_KZERO:  jump = (k == '0);
      JC_IDXGE:  jump = (idx >= n);
      JC_MORE:   jump = ((e + N_W'(1)) < n);
      default:   jump = 1'b0;
    endcase
  end

  always_comb begin
    unique case (cw.rd)
      RD_LVL:  raddr = ADDR_W'(lvl);
      RD_IDX:  raddr = ADDR_W'(idx);
      RD_EMIT: raddr = ADDR_W'(e);
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cw.rd != RD_NONE) begin
      rdata <= mem[raddr];
    end
    if (cw.tmp_ld) begin
      tmp <= rdata;
    end
    if (load_take) begin
      if (32'(position) < MAX_ELEMENTS) begin
        mem[ADDR_W'(position)] <= value;
      end
    end else if (cw.wr == WR_LVL) begin
      mem[ADDR_W'(lvl)] <= rdata;
    end else if (cw.wr == WR_IDX) begin
      mem[ADDR_W'(idx)] <= tmp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run          <= 1'b0;
      pc           <= S_DISPATCH;
      started      <= 1'b0;
      finished     <= 1'b0;
      count_in_use <= COUNT_RESET;
      strobe       <= 1'b0;
      for (int j = 0; j < MAX_ELEMENTS; j++) begin
        level_index[j] <= '0;
      end
    end else begin
      strobe <= 1'b0;
      if (wr_en) begin
        count_in_use <= wr_data;
      end
      if (wr_en || load_take) begin
        started  <= 1'b0;
        finished <= 1'b0;
        for (int j = 0; j < MAX_ELEMENTS; j++) begin
          level_index[j] <= '0;
        end
      end
      if (take && action) begin
        run <= 1'b1;
        pc  <= S_DISPATCH;
        e   <= '0;
      end else if (run) begin
        if (cw.fin) begin
          run <= 1'b0;
        end
        pc <= jump ? cw.target : pc + pc_t'(1);
      end
      if (cw.rd == RD_EMIT) begin
        e            <= e + N_W'(1);
        strobe       <= 1'b1;
        out_position <= POS_W'(e);
        last_element <= ((e + N_W'(1)) == n);
        done_res     <= 1'b0;
      end
      unique case (cw.op)
        OP_NONE: begin
        end
        OP_SETK: begin
          k <= n - N_W'(1);
          e <= '0;
        end
        OP_LOADIDX: begin
          idx <= N_W'(level_index[ADDR_W'(lvl)]);
        end
        OP_INCIDX: begin
          idx <= idx + N_W'(1);
        end
        OP_COMMIT: begin
          level_index[ADDR_W'(lvl)] <= ADDR_W'(idx);
          for (int j = 0; j < MAX_ELEMENTS; j++) begin
            if ((j > 32'(lvl)) && (j + 1 < 32'(n))) begin
              level_index[j] <= ADDR_W'(j);
            end
          end
        end
        OP_RESTORE: begin
          level_index[ADDR_W'(lvl)] <= ADDR_W'(lvl);
          k <= lvl;
        end
        OP_DESCEND0: begin
          started <= 1'b1;
          for (int j = 0; j < MAX_ELEMENTS; j++) begin
            if (j + 1 < 32'(n)) begin
              level_index[j] <= ADDR_W'(j);
            end
          end
        end
        OP_FINISH: begin
          finished <= 1'b1;
        end
        OP_DONE: begin
          strobe       <= 1'b1;
          out_position <= '0;
          last_element <= 1'b1;
          done_res     <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

`include "swap_permutation_generator_top_macros.svh"

  `SPG_ASSERT_NEXT(a_idle_quiet, !busy, !strobe)
  `SPG_ASSERT_NOW(a_done_is_last, strobe && done_res, last_element)
  `SPG_ASSERT_NEXT(a_load_no_run, start && !busy && !action, !busy)
  `SPG_ASSERT_NOW(a_emit_bound, busy, e <= n)

endmodule
